### hdl/mil_pkg.sv
// Package for the LU matrix inverter: sizes, fixed-point helpers and command types.
// Used by the controller, the datapath and the top level; depends on nothing.
package mil_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIM_W         = 4;
  localparam int SEL_W         = 2;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 3;

  localparam logic [0:0] CFG_DIMENSION  = 1'b0;
  localparam logic [0:0] CFG_OUTPUT_SEL = 1'b1;

  localparam logic [SEL_W-1:0] SEL_LOWER = 2'd1;
  localparam logic [SEL_W-1:0] SEL_UPPER = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOWER,
    OP_UPPER,
    OP_FORWARD,
    OP_BACK
  } op_t;

  // One entry computation requested by the controller.
  typedef struct packed {
    logic       start;
    op_t        op;
    logic [4:0] row;
    logic [4:0] col;
    logic [4:0] k_lo;
    logic [4:0] k_hi;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    hi = 96'sh7fffffff;
    lo = -96'sh80000000;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

### hdl/matrix_inverse_lu.sv
// Matrix inverse by Crout LU decomposition: loads n*n elements, returns the inverse, L or U.
// After the last element is loaded the block is busy for the factor and substitution passes:
// each product term steps through read, multiply and accumulate, constant entries of the
// factors are written directly, and each of the roughly 2.5*n*n divided entries waits on
// the bit-serial divider (one quotient bit per cycle over 96 bits). Results then stream out
// one at a time under out_ready.
// Depends on mil_pkg, mil_ctrl, mil_datapath and mil_div.
module matrix_inverse_lu #(
  parameter int MAX_DIM   = mil_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mil_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_element,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_value,
  output logic [2:0]          out_row_index,
  output logic [2:0]          out_col_index,
  output logic                out_last,
  output logic                out_singular
);

  logic          load_we;
  logic [4:0]    load_row, load_col, rd_row, rd_col;
  mil_pkg::cmd_t cmd;
  mil_pkg::sts_t sts;
  logic          rd_en;
  logic [1:0]    rd_sel;

  mil_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_index),
    .cfg_dim   (cfg_data),
    .cfg_sel   (cfg_data[1:0]),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .load_we   (load_we),
    .load_row  (load_row),
    .load_col  (load_col),
    .cmd       (cmd),
    .sts       (sts),
    .rd_en     (rd_en),
    .rd_sel    (rd_sel),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row_index),
    .out_col   (out_col_index),
    .out_last  (out_last)
  );

  mil_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_we   (load_we),
    .load_row  (load_row),
    .load_col  (load_col),
    .load_data (in_element),
    .cmd       (cmd),
    .sts       (sts),
    .rd_en     (rd_en),
    .rd_sel    (rd_sel),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .rd_data   (out_value),
    .pivot_err (out_singular)
  );

endmodule

### hdl/mil_div.sv
// Restoring divider for the LU matrix inverter: signed 96/32 truncating division.
// Depends on no package; one quotient bit per cycle.
module mil_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [95:0]  num,
  input  logic signed [31:0]  den,
  output logic                done,
  output logic signed [95:0]  quot
);

  logic [95:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_r[31:0], q_r[95]};
    trial   = shifted - {1'b0, d_r};
    q_nxt   = {q_r[94:0], ~trial[32]};
    rem_nxt = trial[32] ? shifted : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 7'd96;
        q_r   <= num[95] ? 96'(-num) : num;
        rem_r <= '0;
        d_r   <= den[31] ? 32'(-den) : den;
        neg_r <= num[95] ^ den[31];
      end else if (run_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? 96'(-q_r) : q_r;

endmodule

### hdl/mil_datapath.sv
// Datapath of the LU matrix inverter: five matrix memories, multiply-accumulate and divide.
// Depends on mil_pkg and mil_div; commanded by mil_ctrl.
module mil_datapath #(
  parameter int MAX_DIM   = mil_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mil_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_we,
  input  logic [4:0]          load_row,
  input  logic [4:0]          load_col,
  input  logic signed [31:0]  load_data,
  input  mil_pkg::cmd_t       cmd,
  output mil_pkg::sts_t       sts,
  input  logic                rd_en,
  input  logic [1:0]          rd_sel,
  input  logic [4:0]          rd_row,
  input  logic [4:0]          rd_col,
  output logic signed [31:0]  rd_data,
  output logic                pivot_err
);

  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int RW    = $clog2(MAX_DIM);
  localparam logic signed [63:0] PROD_RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  typedef enum logic [2:0] {
    D_IDLE, D_RD, D_MUL, D_ACC, D_DIVW, D_WR
  } dstate_t;

  logic signed [31:0] a_mem [CELLS];
  logic signed [31:0] l_mem [CELLS];
  logic signed [31:0] u_mem [CELLS];
  logic signed [31:0] f_mem [CELLS];
  logic signed [31:0] x_mem [CELLS];

  dstate_t            st_r;
  mil_pkg::op_t       op_r;
  logic [4:0]         row_r, col_r, k_r, khi_r;
  logic signed [95:0] acc_r;
  logic signed [31:0] opa_r, opb_r, piv_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_q;
  logic               fix_r;
  logic               cmd_fix;
  logic               err_r;
  logic               done_r;
  logic               div_start_r;
  logic               div_done;
  logic signed [95:0] quot;
  logic signed [31:0] result;

  function automatic logic [AW-1:0] addr(input logic [4:0] r, input logic [4:0] c);
    addr = AW'(r[RW-1:0] * MAX_DIM + c[RW-1:0]);
  endfunction

  mil_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (acc_r <<< FRAC_BITS),
    .den   (piv_r),
    .done  (div_done),
    .quot  (quot)
  );

  // Entries outside a factor's triangle and the unit diagonal of U are constants.
  assign cmd_fix = ((cmd.op == mil_pkg::OP_LOWER) && (cmd.row < cmd.col)) ||
                   ((cmd.op == mil_pkg::OP_UPPER) && (cmd.row >= cmd.col));

  // The product is scaled down with truncation toward zero.
  assign prod_q = (prod_r + (prod_r[63] ? PROD_RND : 64'sd0)) >>> FRAC_BITS;

  always_comb begin
    result = mil_pkg::sat32(acc_r);
    if (op_r != mil_pkg::OP_LOWER && !fix_r) begin
      result = (piv_r == 32'sd0) ? 32'sd0 : mil_pkg::sat32(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      a_mem[addr(load_row, load_col)] <= load_data;
    end
    if (rd_en) begin
      case (rd_sel)
        mil_pkg::SEL_LOWER: rd_data <= l_mem[addr(rd_row, rd_col)];
        mil_pkg::SEL_UPPER: rd_data <= u_mem[addr(rd_row, rd_col)];
        default:            rd_data <= x_mem[addr(rd_row, rd_col)];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= D_IDLE;
      err_r       <= 1'b0;
      done_r      <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      done_r      <= 1'b0;
      div_start_r <= 1'b0;
      if (load_we) begin
        err_r <= 1'b0;
      end
      case (st_r)
        D_IDLE: begin
          if (cmd.start) begin
            op_r  <= cmd.op;
            row_r <= cmd.row;
            col_r <= cmd.col;
            khi_r <= cmd.k_hi;
            fix_r <= cmd_fix;
            if (cmd_fix) begin
              k_r   <= cmd.k_hi;
              acc_r <= (cmd.row == cmd.col) ? 96'(1) <<< FRAC_BITS : 96'sd0;
            end else begin
              k_r <= cmd.k_lo;
              case (cmd.op)
                mil_pkg::OP_LOWER, mil_pkg::OP_UPPER:
                  acc_r <= 96'(a_mem[addr(cmd.row, cmd.col)]);
                mil_pkg::OP_FORWARD:
                  acc_r <= (cmd.row == cmd.col) ? 96'(1) <<< FRAC_BITS : 96'sd0;
                default:
                  acc_r <= 96'(f_mem[addr(cmd.row, cmd.col)]);
              endcase
            end
            st_r <= D_RD;
          end
        end
        D_RD: begin
          if (k_r == khi_r) begin
            if (fix_r || op_r == mil_pkg::OP_LOWER) begin
              st_r <= D_WR;
            end else begin
              case (op_r)
                mil_pkg::OP_UPPER:   piv_r <= l_mem[addr(row_r, row_r)];
                mil_pkg::OP_FORWARD: piv_r <= l_mem[addr(row_r, row_r)];
                default:             piv_r <= u_mem[addr(row_r, row_r)];
              endcase
              div_start_r <= 1'b1;
              st_r        <= D_DIVW;
            end
          end else begin
            case (op_r)
              mil_pkg::OP_LOWER: begin
                opa_r <= l_mem[addr(row_r, k_r)];
                opb_r <= u_mem[addr(k_r, col_r)];
              end
              mil_pkg::OP_UPPER: begin
                opa_r <= l_mem[addr(row_r, k_r)];
                opb_r <= u_mem[addr(k_r, col_r)];
              end
              mil_pkg::OP_FORWARD: begin
                opa_r <= l_mem[addr(row_r, k_r)];
                opb_r <= f_mem[addr(k_r, col_r)];
              end
              default: begin
                opa_r <= u_mem[addr(row_r, k_r)];
                opb_r <= x_mem[addr(k_r, col_r)];
              end
            endcase
            st_r <= D_MUL;
          end
        end
        D_MUL: begin
          prod_r <= 64'(opa_r) * 64'(opb_r);
          st_r   <= D_ACC;
        end
        D_ACC: begin
          acc_r <= acc_r - 96'(mil_pkg::sat32(96'(prod_q)));
          k_r   <= k_r + 5'd1;
          st_r  <= D_RD;
        end
        D_DIVW: begin
          if (div_done) begin
            st_r <= D_WR;
          end
        end
        D_WR: begin
          case (op_r)
            mil_pkg::OP_LOWER:   l_mem[addr(row_r, col_r)] <= result;
            mil_pkg::OP_UPPER:   u_mem[addr(row_r, col_r)] <= result;
            mil_pkg::OP_FORWARD: f_mem[addr(row_r, col_r)] <= result;
            default:             x_mem[addr(row_r, col_r)] <= result;
          endcase
          if (op_r != mil_pkg::OP_LOWER && !fix_r && piv_r == 32'sd0) begin
            err_r <= 1'b1;
          end
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign sts.busy  = (st_r != D_IDLE);
  assign sts.done  = done_r;
  assign pivot_err = err_r;

endmodule

### hdl/mil_ctrl.sv
// Controller of the LU matrix inverter: load counting, entry sequencing and result output.
// Depends on mil_pkg; drives mil_datapath by command and status signals.
module mil_ctrl #(
  parameter int MAX_DIM = mil_pkg::MAX_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [3:0]          cfg_dim,
  input  logic [1:0]          cfg_sel,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                load_we,
  output logic [4:0]          load_row,
  output logic [4:0]          load_col,
  output mil_pkg::cmd_t       cmd,
  input  mil_pkg::sts_t       sts,
  output logic                rd_en,
  output logic [1:0]          rd_sel,
  output logic [4:0]          rd_row,
  output logic [4:0]          rd_col,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_row,
  output logic [2:0]          out_col,
  output logic                out_last
);

  typedef enum logic [2:0] {
    S_LOAD, S_ISSUE, S_WAIT, S_RD, S_OUT
  } state_t;

  state_t       state_r;
  logic [3:0]   dim_r;
  logic [1:0]   sel_r;
  logic [4:0]   n;
  logic [4:0]   lr_r, lc_r;
  mil_pkg::op_t ph_r;
  logic [4:0]   i_r, j_r;
  logic [4:0]   orow_r, ocol_r;
  logic         ov_r;
  logic         olast_r;
  logic         cmd_start_r;
  logic [4:0]   c_row, c_col, c_klo, c_khi, brow;
  logic         accept;

  always_comb begin
    n = 5'(dim_r);
    if (dim_r == 4'd0) begin
      n = 5'd1;
    end else if (32'(dim_r) > MAX_DIM) begin
      n = 5'(MAX_DIM);
    end
  end

  // Indices of the current entry; j runs along the pass, i is the outer index.
  always_comb begin
    brow  = n - 5'd1 - j_r;
    c_row = j_r;
    c_col = i_r;
    c_klo = 5'd0;
    c_khi = i_r;
    case (ph_r)
      mil_pkg::OP_LOWER: begin
        c_row = j_r;
      end
      mil_pkg::OP_UPPER: begin
        c_row = i_r;
        c_col = j_r;
      end
      mil_pkg::OP_FORWARD: begin
        c_khi = j_r;
      end
      default: begin
        c_row = brow;
        c_klo = brow + 5'd1;
        c_khi = n;
      end
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_LOAD) && !ov_r;
  assign load_we  = accept;
  assign load_row = lr_r;
  assign load_col = lc_r;

  always_comb begin
    cmd       = '0;
    cmd.start = cmd_start_r;
    cmd.op    = ph_r;
    cmd.row   = c_row;
    cmd.col   = c_col;
    cmd.k_lo  = c_klo;
    cmd.k_hi  = c_khi;
  end

  assign rd_en     = (state_r == S_RD);
  assign rd_sel    = sel_r;
  assign rd_row    = orow_r;
  assign rd_col    = ocol_r;
  assign out_valid = ov_r;
  assign out_row   = orow_r[2:0];
  assign out_col   = ocol_r[2:0];
  assign out_last  = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      dim_r       <= 4'd4;
      sel_r       <= 2'd0;
      lr_r        <= '0;
      lc_r        <= '0;
      ph_r        <= mil_pkg::OP_LOWER;
      i_r         <= '0;
      j_r         <= '0;
      orow_r      <= '0;
      ocol_r      <= '0;
      ov_r        <= 1'b0;
      olast_r     <= 1'b0;
      cmd_start_r <= 1'b0;
    end else begin
      cmd_start_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_idx == mil_pkg::CFG_DIMENSION) begin
          dim_r <= cfg_dim;
          lr_r  <= '0;
          lc_r  <= '0;
        end else begin
          sel_r <= cfg_sel;
        end
      end
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (lc_r == n - 5'd1) begin
              lc_r <= '0;
              if (lr_r == n - 5'd1) begin
                lr_r    <= '0;
                ph_r    <= mil_pkg::OP_LOWER;
                i_r     <= '0;
                j_r     <= '0;
                state_r <= S_ISSUE;
              end else begin
                lr_r <= lr_r + 5'd1;
              end
            end else begin
              lc_r <= lc_r + 5'd1;
            end
          end
        end
        S_ISSUE: begin
          if (!sts.busy) begin
            cmd_start_r <= 1'b1;
            state_r     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sts.done) begin
            state_r <= S_ISSUE;
            if (j_r == n - 5'd1) begin
              j_r <= '0;
              case (ph_r)
                mil_pkg::OP_LOWER: ph_r <= mil_pkg::OP_UPPER;
                mil_pkg::OP_UPPER: begin
                  if (i_r == n - 5'd1) begin
                    ph_r <= mil_pkg::OP_FORWARD;
                    i_r  <= '0;
                  end else begin
                    ph_r <= mil_pkg::OP_LOWER;
                    i_r  <= i_r + 5'd1;
                  end
                end
                mil_pkg::OP_FORWARD: begin
                  if (i_r == n - 5'd1) begin
                    ph_r <= mil_pkg::OP_BACK;
                    i_r  <= '0;
                  end else begin
                    i_r <= i_r + 5'd1;
                  end
                end
                default: begin
                  if (i_r == n - 5'd1) begin
                    orow_r  <= '0;
                    ocol_r  <= '0;
                    state_r <= S_RD;
                  end else begin
                    i_r <= i_r + 5'd1;
                  end
                end
              endcase
            end else begin
              j_r <= j_r + 5'd1;
            end
          end
        end
        S_RD: begin
          ov_r    <= 1'b1;
          olast_r <= (orow_r == n - 5'd1) && (ocol_r == n - 5'd1);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (ov_r && out_ready) begin
            ov_r <= 1'b0;
            if (olast_r) begin
              state_r <= S_LOAD;
            end else begin
              state_r <= S_RD;
              if (ocol_r == n - 5'd1) begin
                ocol_r <= '0;
                orow_r <= orow_r + 5'd1;
              end else begin
                ocol_r <= ocol_r + 5'd1;
              end
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.busy) else $error("input taken while datapath busy");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_start_r |-> !sts.busy) else $error("command issued to busy datapath");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(orow_r) && $stable(ocol_r))
    else $error("result dropped");
`endif

endmodule
